// ===== hw/rtl/wfas_pkg.sv =====
package wfas_pkg;

  localparam int HISTORY_DEPTH_DEFAULT = 64;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEAUTH_LIMIT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_LIMIT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MS        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GIANT_BEACON_LEN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_BEACON_LEN  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_DATA_LEN   = 3'd6;

  localparam logic [8:0]  RST_ATTACK_THRESHOLD = 9'd128;
  localparam logic [15:0] RST_DEAUTH_LIMIT     = 16'd10;
  localparam logic [15:0] RST_PROBE_LIMIT      = 16'd50;
  localparam logic [15:0] RST_WINDOW_MS        = 16'd1000;
  localparam logic [15:0] RST_GIANT_BEACON_LEN = 16'd1000;
  localparam logic [15:0] RST_LONG_BEACON_LEN  = 16'd300;
  localparam logic [15:0] RST_SHORT_DATA_LEN   = 16'd10;

  localparam logic       CMD_FRAME = 1'b0;
  localparam logic       CMD_CLEAR = 1'b1;

  localparam logic [1:0] TYPE_MGMT     = 2'd0;
  localparam logic [1:0] TYPE_DATA     = 2'd2;
  localparam logic [1:0] TYPE_RESERVED = 2'd3;

  localparam logic [3:0] SUB_PROBE_REQ = 4'd4;
  localparam logic [3:0] SUB_BEACON    = 4'd8;
  localparam logic [3:0] SUB_DEAUTH    = 4'd12;

  localparam logic [4:0] PTS_GIANT_BEACON = 5'd8;
  localparam logic [4:0] PTS_LONG_BEACON  = 5'd4;
  localparam logic [4:0] PTS_SHORT_DATA   = 5'd2;
  localparam logic [4:0] PTS_RESERVED     = 5'd10;
  localparam logic [4:0] PTS_DEAUTH_FLOOD = 5'd9;
  localparam logic [4:0] PTS_PROBE_FLOOD  = 5'd3;
  localparam logic [4:0] SCORE_MAX        = 5'd10;

  localparam logic [3:0] WEIGHT_RESERVED = 4'd10;
  localparam logic [3:0] WEIGHT_DEAUTH   = 4'd3;
  localparam logic [3:0] WEIGHT_NONE     = 4'd0;

  localparam logic [15:0] COUNTER_MAX = 16'hFFFF;

  localparam int QUOT_W = 9;

  typedef struct packed {
    logic        command;
    logic [15:0] frame_length;
    logic [1:0]  frame_type;
    logic [3:0]  frame_subtype;
    logic [31:0] time_ms;
  } wfas_in_t;

  typedef struct packed {
    logic [3:0] frame_score;
    logic [8:0] average_score;
    logic       under_attack;
    logic [6:0] history_count;
  } wfas_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCORE,
    S_HIST,
    S_PREP,
    S_DIV,
    S_FINISH
  } wfas_state_t;

endpackage

// ===== hw/rtl/wifi_frame_anomaly_scorer_core.sv =====
// wifi frame anomaly scorer
// input channel in_valid/in_ready carries one frame descriptor or a clear
// command per item; output channel out_valid/out_ready returns one result
// item (frame score, history average, attack flag, history count) per input.
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, which the block does not enforce.
// an item passes from acceptance to out_valid through scoring, one ring
// memory read and update, operand set-up, nine steps of the restoring
// divider for the average, and a final compare for the flag.
// in_ready is high only between items, so a new item is taken only once
// the previous one has left the final step.
// a finished result sits in the output register; the next item can be
// accepted meanwhile, and its result waits in the final step until the
// previous one has been taken when the receiver stalls.
// reset restores the register defaults and empties counters and history;
// the history ring itself is not cleared, only its fill count, head and total.
module wifi_frame_anomaly_scorer_core #(
  parameter int HISTORY_DEPTH = wfas_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  wfas_pkg::wfas_in_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output wfas_pkg::wfas_out_t                   out_item,
  input  logic                                  cfg_we,
  input  logic [wfas_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wfas_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import wfas_pkg::*;

  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int TW = $clog2(10 * HISTORY_DEPTH + 1);
  localparam int DW = TW;
  localparam int SW = TW + 9;
  localparam logic [HW-1:0] HEAD_LAST = HW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);

  logic [8:0]  attack_threshold;
  logic [15:0] deauth_limit, probe_limit, window_ms;
  logic [15:0] giant_beacon_len, long_beacon_len, short_data_len;

  wfas_state_t state, state_next;

  wfas_in_t    item;
  logic [15:0] deauth_counter, probe_counter;
  logic [31:0] window_start_ms;
  logic [HW-1:0] history_head;
  logic [FW-1:0] history_fill;
  logic [TW-1:0] history_total;
  logic [3:0]  weight;
  logic [3:0]  score;

  logic [3:0]  history_weights [HISTORY_DEPTH];
  logic [3:0]  rd_weight;

  logic [DW-1:0] den;
  logic [SW-1:0] num;
  logic [SW-1:0] rem;
  logic [SW-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [3:0]  step;

  // scoring terms
  logic        mgmt, beacon, deauth, probe;
  logic [15:0] deauth_inc, probe_inc;
  logic [31:0] elapsed;
  logic [4:0]  raw_score;
  logic [3:0]  weight_calc;
  logic [SW-1:0] den_shift;
  logic        take;
  logic [DW-1:0] den_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_threshold <= RST_ATTACK_THRESHOLD;
      deauth_limit     <= RST_DEAUTH_LIMIT;
      probe_limit      <= RST_PROBE_LIMIT;
      window_ms        <= RST_WINDOW_MS;
      giant_beacon_len <= RST_GIANT_BEACON_LEN;
      long_beacon_len  <= RST_LONG_BEACON_LEN;
      short_data_len   <= RST_SHORT_DATA_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTACK_THRESHOLD: attack_threshold <= cfg_data[8:0];
        CFG_DEAUTH_LIMIT:     deauth_limit     <= cfg_data;
        CFG_PROBE_LIMIT:      probe_limit      <= cfg_data;
        CFG_WINDOW_MS:        window_ms        <= cfg_data;
        CFG_GIANT_BEACON_LEN: giant_beacon_len <= cfg_data;
        CFG_LONG_BEACON_LEN:  long_beacon_len  <= cfg_data;
        CFG_SHORT_DATA_LEN:   short_data_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mgmt   = (item.frame_type == TYPE_MGMT);
    beacon = mgmt && (item.frame_subtype == SUB_BEACON);
    deauth = mgmt && (item.frame_subtype == SUB_DEAUTH);
    probe  = mgmt && (item.frame_subtype == SUB_PROBE_REQ);
    deauth_inc = (deauth && deauth_counter != COUNTER_MAX) ? deauth_counter + 16'd1
                                                           : deauth_counter;
    probe_inc  = (probe && probe_counter != COUNTER_MAX) ? probe_counter + 16'd1
                                                         : probe_counter;
    elapsed = item.time_ms - window_start_ms;
    raw_score = '0;
    if (beacon && item.frame_length > giant_beacon_len) raw_score = raw_score + PTS_GIANT_BEACON;
    if (item.frame_type == TYPE_DATA && item.frame_length < short_data_len) begin
      raw_score = raw_score + PTS_SHORT_DATA;
    end
    if (item.frame_type == TYPE_RESERVED) raw_score = raw_score + PTS_RESERVED;
    if (deauth && deauth_inc > deauth_limit) raw_score = raw_score + PTS_DEAUTH_FLOOD;
    if (probe && probe_inc > probe_limit) raw_score = raw_score + PTS_PROBE_FLOOD;
    if (beacon && item.frame_length > long_beacon_len) raw_score = raw_score + PTS_LONG_BEACON;
    if (raw_score > SCORE_MAX) raw_score = SCORE_MAX;
    if (item.frame_type == TYPE_RESERVED) begin
      weight_calc = WEIGHT_RESERVED;
    end else if (deauth) begin
      weight_calc = WEIGHT_DEAUTH;
    end else begin
      weight_calc = WEIGHT_NONE;
    end
    den_calc  = (DW'(history_fill) << 3) + (DW'(history_fill) << 1);
    den_shift = SW'(den) << step;
    take      = (rem >= den_shift);
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_SCORE;
      end
      S_SCORE:  state_next = S_HIST;
      S_HIST:   state_next = S_PREP;
      S_PREP:   state_next = S_DIV;
      S_DIV:    if (step == 4'd0) state_next = S_FINISH;
      S_FINISH: if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // history ring
  always_ff @(posedge clk) begin
    rd_weight <= history_weights[history_head];
    if (state == S_HIST && item.command == CMD_FRAME) history_weights[history_head] <= weight;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deauth_counter  <= '0;
      probe_counter   <= '0;
      window_start_ms <= '0;
      history_head    <= '0;
      history_fill    <= '0;
      history_total   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) item <= in_item;
        end
        S_SCORE: begin
          if (item.command == CMD_CLEAR) begin
            deauth_counter  <= '0;
            probe_counter   <= '0;
            window_start_ms <= item.time_ms;
            history_head    <= '0;
            history_fill    <= '0;
            history_total   <= '0;
            score           <= '0;
          end else begin
            score  <= raw_score[3:0];
            weight <= weight_calc;
            if (elapsed > {16'd0, window_ms}) begin
              deauth_counter  <= '0;
              probe_counter   <= '0;
              window_start_ms <= item.time_ms;
            end else begin
              deauth_counter <= deauth_inc;
              probe_counter  <= probe_inc;
            end
          end
        end
        S_HIST: begin
          if (item.command == CMD_FRAME) begin
            if (history_fill == FILL_FULL) begin
              history_total <= history_total - TW'(rd_weight) + TW'(weight);
            end else begin
              history_fill  <= history_fill + FW'(1);
              history_total <= history_total + TW'(weight);
            end
            history_head <= (history_head == HEAD_LAST) ? '0 : history_head + HW'(1);
          end
        end
        S_PREP: begin
          den  <= den_calc;
          num  <= SW'({history_total, 8'd0});
          rem  <= SW'({history_total, 8'd0});
          quot <= '0;
          step <= 4'(QUOT_W - 1);
        end
        S_DIV: begin
          if (step == 4'(QUOT_W - 1)) prod <= SW'(attack_threshold * den);
          if (take) begin
            rem        <= rem - den_shift;
            quot[step] <= 1'b1;
          end
          if (step != 4'd0) step <= step - 4'd1;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_item.frame_score   <= score;
            out_item.average_score <= (history_fill != '0) ? quot : '0;
            out_item.under_attack  <= (history_fill != '0) && (num > prod);
            out_item.history_count <= 7'(history_fill);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/wfas_core_checker.sv =====
module wfas_core_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input wfas_pkg::wfas_out_t out_item
);
  import wfas_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed or dropped while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.frame_score <= 4'd10)
    else $error("frame score above clamp");

  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.average_score <= 9'd256)
    else $error("average above one");

  a_empty_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.history_count == 7'd0 |->
      out_item.average_score == 9'd0 && !out_item.under_attack)
    else $error("empty history gives nonzero average or flag");

endmodule

bind wifi_frame_anomaly_scorer_core wfas_core_checker u_wfas_core_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wfas_pkg::*;

  localparam int DEPTH            = HISTORY_DEPTH_DEFAULT;
  localparam int N_REGS           = 7;
  localparam int N_PHASES         = 8;
  localparam int RANDOM_PER_PHASE = 135;
  localparam int HOLD_CYCLES      = 600;
  localparam int LIMIT_CYCLES     = 500000;
  localparam int N_PLAN           = 17;

  localparam logic [1:0] TYPE_CTRL = 2'd1;

  // register sets in index order: threshold, deauth, probe, window, giant, long, short
  localparam logic [15:0] REG_SETS [6][N_REGS] = '{
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd256, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'd511, 16'd3, 16'd5, 16'd20, 16'd500, 16'd100, 16'd64},
    '{16'd40, 16'd2, 16'd4, 16'd100, 16'd1200, 16'd200, 16'd30},
    '{16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFE, 16'd1, 16'd1},
    '{16'(RST_ATTACK_THRESHOLD), RST_DEAUTH_LIMIT, RST_PROBE_LIMIT, RST_WINDOW_MS,
      RST_GIANT_BEACON_LEN, RST_LONG_BEACON_LEN, RST_SHORT_DATA_LEN}
  };

  typedef struct {
    wfas_in_t  item;
    int        reps;
    int        dt;
    bit        known;
    wfas_out_t want;
  } stim_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  wfas_in_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  wfas_out_t              out_item;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // scorer model state
  logic [8:0]  thr_q;
  logic [15:0] deauth_lim_q, probe_lim_q, window_q, giant_q, long_q, short_q;
  logic [15:0] deauth_cnt, probe_cnt;
  logic [31:0] win_start;
  logic [3:0]  ring [DEPTH];
  logic [5:0]  head;
  logic [6:0]  fill;
  logic [9:0]  total;

  wfas_out_t   pending_scores [$];
  logic [15:0] next_regs [N_REGS];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  bit          idle_on        = 1'b1;
  int          hold_requests  = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  logic [31:0] clock_ms       = '0;
  int          burst_left     = 0;
  logic [3:0]  burst_sub      = SUB_DEAUTH;

  stim_row_t plan [N_PLAN] = '{
    '{'{CMD_CLEAR, 16'd0, TYPE_MGMT, 4'd0, 32'd0}, 1, 0, 1'b1, '{4'd0, 9'd0, 1'b0, 7'd0}},
    '{'{CMD_FRAME, 16'd0, TYPE_RESERVED, 4'd0, 32'd1}, 1, 0, 1'b1,
      '{4'd10, 9'd256, 1'b1, 7'd1}},
    '{'{CMD_FRAME, 16'hFFFF, TYPE_MGMT, SUB_BEACON, 32'd2}, 1, 0, 1'b1,
      '{4'd10, 9'd128, 1'b0, 7'd2}},
    '{'{CMD_FRAME, 16'd1000, TYPE_MGMT, SUB_BEACON, 32'd3}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'd301, TYPE_MGMT, SUB_BEACON, 32'd4}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'd300, TYPE_MGMT, SUB_BEACON, 32'd5}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'd0, TYPE_DATA, 4'd0, 32'd6}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'd9, TYPE_DATA, 4'd0, 32'd7}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'd10, TYPE_DATA, 4'hF, 32'd8}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'hFFFF, TYPE_CTRL, 4'hF, 32'd9}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'd26, TYPE_MGMT, SUB_DEAUTH, 32'd10}, 12, 1, 1'b0, '0},
    '{'{CMD_FRAME, 16'd26, TYPE_MGMT, SUB_DEAUTH, 32'd1022}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'd0, TYPE_MGMT, SUB_PROBE_REQ, 32'd1023}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'd50, TYPE_CTRL, SUB_PROBE_REQ, 32'd1024}, 1, 0, 1'b0, '0},
    '{'{CMD_CLEAR, 16'hFFFF, TYPE_RESERVED, 4'hF, 32'hFFFF_FFF0}, 1, 0, 1'b1,
      '{4'd0, 9'd0, 1'b0, 7'd0}},
    '{'{CMD_FRAME, 16'd26, TYPE_MGMT, SUB_DEAUTH, 32'd5}, 1, 0, 1'b0, '0},
    '{'{CMD_FRAME, 16'hFFFF, TYPE_MGMT, 4'hF, 32'hFFFF_FFFF}, 1, 0, 1'b0, '0}
  };

  wifi_frame_anomaly_scorer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic wfas_out_t score_frame(input wfas_in_t f);
    wfas_out_t   r;
    logic [4:0]  pts;
    logic [3:0]  w;
    logic        is_mgmt, is_beacon, is_deauth, is_probe;
    logic [31:0] elapsed;
    int unsigned num, den;
    r = '0;
    pts = '0;
    w = WEIGHT_NONE;
    if (f.command == CMD_CLEAR) begin
      deauth_cnt = '0;
      probe_cnt = '0;
      win_start = f.time_ms;
      head = '0;
      fill = '0;
      total = '0;
    end else begin
      is_mgmt   = (f.frame_type == TYPE_MGMT);
      is_beacon = is_mgmt && f.frame_subtype == SUB_BEACON;
      is_deauth = is_mgmt && f.frame_subtype == SUB_DEAUTH;
      is_probe  = is_mgmt && f.frame_subtype == SUB_PROBE_REQ;
      if (is_beacon && f.frame_length > giant_q) pts += PTS_GIANT_BEACON;
      if (f.frame_type == TYPE_DATA && f.frame_length < short_q) pts += PTS_SHORT_DATA;
      if (f.frame_type == TYPE_RESERVED) pts += PTS_RESERVED;
      if (is_deauth) begin
        if (deauth_cnt != COUNTER_MAX) deauth_cnt++;
        if (deauth_cnt > deauth_lim_q) pts += PTS_DEAUTH_FLOOD;
      end
      if (is_probe) begin
        if (probe_cnt != COUNTER_MAX) probe_cnt++;
        if (probe_cnt > probe_lim_q) pts += PTS_PROBE_FLOOD;
      end
      if (is_beacon && f.frame_length > long_q) pts += PTS_LONG_BEACON;
      if (pts > SCORE_MAX) pts = SCORE_MAX;
      // window test comes after the flood rules
      elapsed = f.time_ms - win_start;
      if (elapsed > 32'(window_q)) begin
        deauth_cnt = '0;
        probe_cnt = '0;
        win_start = f.time_ms;
      end
      if (f.frame_type == TYPE_RESERVED) w = WEIGHT_RESERVED;
      else if (is_deauth) w = WEIGHT_DEAUTH;
      if (fill == DEPTH) total -= 10'(ring[head]);
      else fill++;
      ring[head] = w;
      total += 10'(w);
      head++;
    end
    r.frame_score = pts[3:0];
    if (fill != 0) begin
      num = 32'(total) * 256;
      den = 32'(fill) * 10;
      r.average_score = 9'(num / den);
      r.under_attack = (num > 32'(thr_q) * den);
    end
    r.history_count = fill;
    return r;
  endfunction

  function automatic wfas_in_t next_frame();
    wfas_in_t   f;
    int         pick;
    logic [15:0] base;
    pick = $urandom_range(99);
    if (pick < 85) clock_ms += 32'($urandom_range(0, 8));
    else if (pick < 95) clock_ms += 32'($urandom_range(0, 2000));
    else clock_ms = $urandom();
    f.command = CMD_FRAME;
    f.frame_length = 16'($urandom());
    f.frame_type = 2'($urandom_range(3));
    f.frame_subtype = 4'($urandom_range(15));
    f.time_ms = clock_ms;
    if (burst_left > 0) begin
      burst_left--;
      f.frame_type = TYPE_MGMT;
      f.frame_subtype = burst_sub;
      return f;
    end
    pick = $urandom_range(199);
    if (pick < 3) begin
      f.command = CMD_CLEAR;
    end else if (pick < 33) begin
      // flood burst of deauth or probe requests
      burst_left = $urandom_range(4, 80);
      burst_sub = $urandom_range(1) ? SUB_DEAUTH : SUB_PROBE_REQ;
      f.frame_type = TYPE_MGMT;
      f.frame_subtype = burst_sub;
    end else begin
      if ($urandom_range(99) < 40) begin
        pick = $urandom_range(2);
        f.frame_subtype = (pick == 0) ? SUB_PROBE_REQ : (pick == 1) ? SUB_BEACON : SUB_DEAUTH;
      end
      if ($urandom_range(1)) begin
        pick = $urandom_range(2);
        base = (pick == 0) ? giant_q : (pick == 1) ? long_q : short_q;
        f.frame_length = base + 16'($urandom_range(2)) - 16'd1;
      end
    end
    return f;
  endfunction

  task automatic flag(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_score(input wfas_out_t got);
    wfas_out_t want;
    if (pending_scores.size() == 0) begin
      flag("unexpected item", int'(got), 0);
    end else begin
      want = pending_scores.pop_front();
      if (got.frame_score !== want.frame_score)
        flag("frame_score", got.frame_score, want.frame_score);
      if (got.average_score !== want.average_score)
        flag("average_score", got.average_score, want.average_score);
      if (got.under_attack !== want.under_attack)
        flag("under_attack", got.under_attack, want.under_attack);
      if (got.history_count !== want.history_count)
        flag("history_count", got.history_count, want.history_count);
    end
  endtask

  task automatic send_item(input wfas_in_t it, input bit typed, input wfas_out_t want);
    wfas_out_t predicted;
    if (idle_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predicted = score_frame(it);
    pending_scores.insert(pending_scores.size(), typed ? want : predicted);
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_registers();
    for (int i = 0; i < N_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data <= next_regs[i];
      case (CFG_INDEX_W'(i))
        CFG_ATTACK_THRESHOLD: thr_q = next_regs[i][8:0];
        CFG_DEAUTH_LIMIT:     deauth_lim_q = next_regs[i];
        CFG_PROBE_LIMIT:      probe_lim_q = next_regs[i];
        CFG_WINDOW_MS:        window_q = next_regs[i];
        CFG_GIANT_BEACON_LEN: giant_q = next_regs[i];
        CFG_LONG_BEACON_LEN:  long_q = next_regs[i];
        CFG_SHORT_DATA_LEN:   short_q = next_regs[i];
        default: ;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // result side with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_score(out_item);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 24);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    wfas_in_t frame;
    thr_q = RST_ATTACK_THRESHOLD;
    deauth_lim_q = RST_DEAUTH_LIMIT;
    probe_lim_q = RST_PROBE_LIMIT;
    window_q = RST_WINDOW_MS;
    giant_q = RST_GIANT_BEACON_LEN;
    long_q = RST_LONG_BEACON_LEN;
    short_q = RST_SHORT_DATA_LEN;
    deauth_cnt = '0;
    probe_cnt = '0;
    win_start = '0;
    head = '0;
    fill = '0;
    total = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain(24);
        for (int i = 0; i < N_REGS; i++) next_regs[i] = REG_SETS[(p == 7) ? 5 : p - 1][i];
        if (p == 6) begin
          next_regs[0] = 16'($urandom_range(0, 300));
          next_regs[1] = 16'($urandom_range(0, 20));
          next_regs[2] = 16'($urandom_range(0, 30));
          next_regs[3] = 16'($urandom());
          next_regs[4] = 16'($urandom());
          next_regs[5] = 16'($urandom());
          next_regs[6] = 16'($urandom());
        end
        load_registers();
      end else begin
        foreach (plan[r]) begin
          for (int k = 0; k < plan[r].reps; k++) begin
            frame = plan[r].item;
            frame.time_ms = frame.time_ms + 32'(k * plan[r].dt);
            send_item(frame, plan[r].known, plan[r].want);
          end
        end
      end
      // no idling at all in one whole phase
      idle_on = (p != 3);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 1 && n == 20) hold_requests++;
        if (p == 1 && n == 100) drain(0);
        send_item(next_frame(), 1'b0, '0);
      end
    end

    idle_on = 1'b1;
    drain(30);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wfas_pkg.sv
hw/rtl/wifi_frame_anomaly_scorer_core.sv
hw/rtl/wfas_core_checker.sv
sim/testbench.sv
